/* src/mrrc_pkg.sv */
// Shared constants and types for the Miller-Rabin round checker.
package mrrc_pkg;

    localparam int DEFAULT_WIDTH = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new request and mark the next product as the modular reduction of the base
        logic mul_start;  // start one modular multiplication
        logic mul_sel_sq; // 1: base*base into base, 0: acc*base into acc
        logic y_square;   // 1: multiplication is y*y into acc
        logic strip;      // shift t right by one, count s
        logic exp_shift;  // shift the exponent right by one
        logic dec_s;      // count down remaining squarings
    } mrrc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic bad_n;
        logic t_even;
        logic e_zero;
        logic e_lsb;
        logic acc_is_one;
        logic acc_is_nm1;
        logic s_left;     // more squarings remain
    } mrrc_stat_t;

endpackage

/* src/mrrc_modmul.sv */
// Iterative modular multiplier: shift-and-add with reduction, one bit per cycle.
module mrrc_modmul #(
    parameter int WIDTH = mrrc_pkg::DEFAULT_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic [WIDTH-1:0] n,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] a_reg, b_reg, n_reg, r_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [WIDTH:0]   dbl, dred, add, ared;

    // r = 2r + a_bit*b, each term reduced below n (b must be below n).
    always_comb begin
        dbl  = {r_reg, 1'b0};
        dred = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
        add  = dred + (a_reg[WIDTH-1] ? {1'b0, b_reg} : '0);
        ared = (add >= {1'b0, n_reg}) ? add - {1'b0, n_reg} : add;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
                a_reg    <= a;
                b_reg    <= b;
                n_reg    <= n;
                r_reg    <= '0;
            end else if (busy_reg) begin
                r_reg   <= ared[WIDTH-1:0];
                a_reg   <= {a_reg[WIDTH-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

/* src/mrrc_datapath.sv */
// Datapath: operand registers, exponent, squaring count and the modular multiplier.
module mrrc_datapath #(
    parameter int WIDTH = mrrc_pkg::DEFAULT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [WIDTH-1:0]    candidate,
    input  logic [WIDTH-1:0]    witness,
    input  mrrc_pkg::mrrc_cmd_t cmd,
    output mrrc_pkg::mrrc_stat_t stat
);

    localparam int SW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] n_reg, base_reg, acc_reg, e_reg;
    logic [SW-1:0]    s_reg;
    logic [WIDTH-1:0] ma, mb, mres;
    logic             mdone, sq_reg, ysq_reg, reduce_reg;

    // Operand selection. The multiplier walks the bits of ma and adds mb, so mb must
    // already be below n. The first product after a load feeds the raw witness as ma
    // and 1 as mb, which reduces a witness of any size below n.
    always_comb begin
        if (cmd.y_square) begin
            ma = acc_reg;
            mb = acc_reg;
        end else if (cmd.mul_sel_sq) begin
            ma = base_reg;
            mb = base_reg;
        end else begin
            ma = base_reg;
            mb = acc_reg;
        end
    end

    mrrc_modmul #(.WIDTH(WIDTH)) u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mul_start),
        .a      (ma),
        .b      (mb),
        .n      (n_reg),
        .done   (mdone),
        .result (mres)
    );

    // Register updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg     <= 1'b0;
            ysq_reg    <= 1'b0;
            reduce_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                n_reg      <= candidate;
                base_reg   <= witness;
                acc_reg    <= WIDTH'(1);
                e_reg      <= candidate - WIDTH'(1);
                s_reg      <= '0;
                reduce_reg <= 1'b1;
            end
            if (cmd.mul_start) begin
                sq_reg  <= cmd.mul_sel_sq;
                ysq_reg <= cmd.y_square;
            end
            if (mdone) begin
                if (reduce_reg) begin
                    base_reg   <= mres;
                    reduce_reg <= 1'b0;
                end else if (sq_reg && !ysq_reg) begin
                    base_reg <= mres;
                end else begin
                    acc_reg <= mres;
                end
            end
            if (cmd.strip) begin
                e_reg <= e_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end else if (cmd.exp_shift) begin
                e_reg <= e_reg >> 1;
            end
            if (cmd.dec_s) begin
                s_reg <= s_reg - 1'b1;
            end
        end
    end

    // Status back to the controller.
    always_comb begin
        stat.mul_done   = mdone;
        stat.bad_n      = (n_reg < WIDTH'(3)) || !n_reg[0];
        stat.t_even     = !e_reg[0];
        stat.e_zero     = (e_reg == '0);
        stat.e_lsb      = e_reg[0];
        stat.acc_is_one = (acc_reg == WIDTH'(1));
        stat.acc_is_nm1 = (acc_reg == n_reg - WIDTH'(1));
        stat.s_left     = (s_reg > SW'(1));
    end

endmodule

/* src/mrrc_ctrl.sv */
// Controller: sequences one round and keeps the sticky composite flag.
module mrrc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_last_round,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_probable_prime,
    output mrrc_pkg::mrrc_cmd_t  cmd,
    input  mrrc_pkg::mrrc_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_CHECK, ST_STRIP, ST_EXP, ST_MUL_WAIT,
        ST_SQ_WAIT, ST_TEST, ST_YSQ_WAIT, ST_YTEST, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   comp_reg, comp_next;
    logic   fail_reg, fail_next;
    logic   mv_reg, mv_next;
    logic   pp_reg, pp_next;
    logic   accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE) && !mv_reg;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        comp_next  = comp_reg;
        fail_next  = fail_reg;
        mv_next    = mv_reg;
        pp_next    = pp_reg;
        cmd        = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    last_next  = s_last_round;
                    fail_next  = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.bad_n) begin
                    fail_next  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (stat.mul_done) begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (stat.t_even) begin
                    cmd.strip = 1'b1;
                end else begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                if (stat.e_zero) begin
                    state_next = ST_TEST;
                end else if (stat.e_lsb) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL_WAIT;
                end else begin
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel_sq = 1'b1;
                    state_next     = ST_SQ_WAIT;
                end
            end
            ST_MUL_WAIT: begin
                if (stat.mul_done) begin
                    cmd.mul_start  = 1'b1;
                    cmd.mul_sel_sq = 1'b1;
                    state_next     = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT: begin
                if (stat.mul_done) begin
                    cmd.exp_shift = 1'b1;
                    state_next    = ST_EXP;
                end
            end
            ST_TEST: begin
                if (stat.acc_is_nm1) begin
                    state_next = ST_FINISH;
                end else if (stat.acc_is_one) begin
                    state_next = ST_FINISH;
                end else if (!stat.s_left) begin
                    fail_next  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.y_square  = 1'b1;
                    cmd.dec_s     = 1'b1;
                    state_next    = ST_YSQ_WAIT;
                end
            end
            ST_YSQ_WAIT: begin
                if (stat.mul_done) begin
                    state_next = ST_YTEST;
                end
            end
            // The squared value is in the accumulator from this cycle on.
            ST_YTEST: begin
                state_next = ST_FINISH;
                if (stat.acc_is_nm1) begin
                    state_next = ST_FINISH;
                end else if (stat.acc_is_one) begin
                    fail_next = 1'b1;
                end else if (!stat.s_left) begin
                    fail_next = 1'b1;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.y_square  = 1'b1;
                    cmd.dec_s     = 1'b1;
                    state_next    = ST_YSQ_WAIT;
                end
            end
            ST_FINISH: begin
                if (last_reg) begin
                    mv_next   = 1'b1;
                    pp_next   = !(comp_reg || fail_reg);
                    comp_next = 1'b0;
                end else begin
                    comp_next = comp_reg || fail_reg;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            comp_reg  <= 1'b0;
            fail_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            pp_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
            comp_reg  <= comp_next;
            fail_reg  <= fail_next;
            mv_reg    <= mv_next;
            pp_reg    <= pp_next;
        end
    end

    assign m_valid          = mv_reg;
    assign m_probable_prime = pp_reg;

    // A request is taken only when idle with no pending verdict.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_CHECK) else $error("accept did not start a round");
    // The composite flag is clear after a verdict is raised.
    a_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> !comp_reg) else $error("flag not cleared after verdict");
    // The verdict holds while it waits.
    a_verdict_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_ready |=> mv_reg && $stable(pp_reg)) else $error("verdict dropped");

endmodule

/* src/miller_rabin_round_checker.sv */
// Miller-Rabin round checker: each request is one round, a verdict follows the last round.
// One request runs one Miller-Rabin round for odd candidate n and a witness. The witness is
// first reduced mod n, n-1 is split into 2^s*t one bit a cycle, then witness^t mod n is formed by
// square-and-multiply and up to s-1 squarings follow. Every modular multiplication goes through
// a single shift-and-add unit, and a round needs at most (2*WIDTH - s) multiplications; a
// candidate that is even or below 3 fails the round at the check, before any multiplication.
// Requests are taken one at a time. A round with last_round set emits probable_prime and
// clears the composite flag gathered so far.
module miller_rabin_round_checker #(
    parameter int WIDTH = mrrc_pkg::DEFAULT_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_candidate,
    input  logic [31:0] s_witness,
    input  logic        s_last_round,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_probable_prime
);

    mrrc_pkg::mrrc_cmd_t  cmd;
    mrrc_pkg::mrrc_stat_t stat;

    mrrc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_round    (s_last_round),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_probable_prime(m_probable_prime),
        .cmd             (cmd),
        .stat            (stat)
    );

    mrrc_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .candidate(s_candidate[WIDTH-1:0]),
        .witness  (s_witness[WIDTH-1:0]),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

/* test/tb_miller_rabin_round_checker.sv */
// Self-checking testbench for the Miller-Rabin round checker.
`timescale 1ns / 100ps

module tb_miller_rabin_round_checker;

    typedef struct {
        bit [31:0] candidate;
        bit [31:0] witness;
        bit        last_round;
        bit        drain_first; // hold this request until every verdict is in
    } round_req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_candidate;
    logic [31:0] s_witness;
    logic        s_last_round;
    logic        m_valid;
    logic        m_ready;
    logic        m_probable_prime;

    round_req_t pending_rounds[$];
    bit         expected_verdicts[$];
    bit         composite_flag;
    bit         req_taken;
    bit         started;
    int         send_gap;
    int         recv_gap;
    int         mismatches;
    int         cycle_count;

    miller_rabin_round_checker dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_candidate      (s_candidate),
        .s_witness        (s_witness),
        .s_last_round     (s_last_round),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_probable_prime (m_probable_prime)
    );

    // Clock generation.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic bit [31:0] mul_mod(bit [31:0] a, bit [31:0] b, bit [31:0] n);
        bit [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return 32'(prod % {32'd0, n});
    endfunction

    // True when this round shows the candidate to be composite.
    function automatic bit round_is_composite(bit [31:0] n, bit [31:0] b);
        bit [31:0] nm1;
        bit [31:0] odd_part;
        bit [31:0] base;
        bit [31:0] acc;
        bit [31:0] e;
        int        twos;
        if (n < 3 || n[0] == 1'b0) begin
            return 1'b1;
        end
        nm1 = n - 1;
        odd_part = nm1;
        twos = 0;
        while (odd_part[0] == 1'b0) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        acc = 1;
        base = b % n;
        e = odd_part;
        while (e != 0) begin
            if (e[0]) begin
                acc = mul_mod(acc, base, n);
            end
            base = mul_mod(base, base, n);
            e = e >> 1;
        end
        if (acc == 1 || acc == nm1) begin
            return 1'b0;
        end
        for (int j = 1; j < twos; j++) begin
            acc = mul_mod(acc, acc, n);
            if (acc == 1) begin
                return 1'b1;
            end
            if (acc == nm1) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic add_round(input bit [31:0] n, input bit [31:0] b, input bit last,
                             input bit drain = 1'b0);
        round_req_t r;
        r.candidate = n;
        r.witness = b;
        r.last_round = last;
        r.drain_first = drain;
        pending_rounds.push_back(r);
    endtask

    function automatic bit [31:0] pick_witness(bit [31:0] n);
        if (n < 5) begin
            return 32'd2;
        end
        return $urandom_range(n - 2, 2);
    endfunction

    // Stimulus: directed rounds, a drain pause, then random tests.
    initial begin
        bit [31:0] primes[$] = '{3, 5, 7, 13, 97, 104729, 65537, 1000000007,
                                 2147483647, 4294967291};
        bit [31:0] composites[$] = '{9, 561, 2047, 1373653, 25326001, 3215031751,
                                     4294967295, 65535};
        bit [31:0] n;
        int        rounds;
        int        kind;
        int        sent;

        // Smallest candidate, largest prime and witness extremes.
        add_round(32'd3, 32'd2, 1'b1);
        add_round(32'd4294967291, 32'd2, 1'b1);
        add_round(32'd4294967291, 32'd4294967289, 1'b0);
        add_round(32'd4294967291, 32'd1, 1'b0);
        add_round(32'd4294967291, 32'd4294967290, 1'b1);
        // Witness reducing to zero, and one beyond the candidate.
        add_round(32'd4294967291, 32'd0, 1'b1);
        add_round(32'd97, 32'hFFFF_FFFF, 1'b1);
        add_round(32'd97, 32'd194, 1'b1);
        // Even or tiny candidates.
        add_round(32'd0, 32'd2, 1'b1);
        add_round(32'd1, 32'hFFFF_FFFF, 1'b1);
        add_round(32'd2, 32'd0, 1'b1);
        add_round(32'hFFFF_FFFE, 32'd3, 1'b1);
        // Strong pseudoprime to base 2 exposed by base 3; flag must clear afterwards.
        add_round(32'd2047, 32'd2, 1'b1);
        add_round(32'd2047, 32'd2, 1'b0);
        add_round(32'd2047, 32'd3, 1'b1);
        add_round(32'd13, 32'd5, 1'b1);
        // Carmichael number and all-ones candidate.
        add_round(32'd561, 32'd2, 1'b1);
        add_round(32'hFFFF_FFFF, 32'h5555_5555, 1'b1);
        add_round(32'd2147483647, 32'hAAAA_AAAA, 1'b1, 1'b1);

        // Random tests, mostly well-formed with a few ill-formed rounds.
        sent = 0;
        while (sent < 130) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                n = primes[$urandom_range(primes.size() - 1)];
            end else if (kind < 60) begin
                n = composites[$urandom_range(composites.size() - 1)];
            end else if (kind < 85) begin
                n = $urandom | 32'd1;
                if (n < 3) begin
                    n = 32'd3;
                end
            end else begin
                n = $urandom;
            end
            rounds = $urandom_range(4, 1);
            for (int r = 0; r < rounds; r++) begin
                if (kind >= 85 || $urandom_range(19) == 0) begin
                    add_round(n, $urandom, r == rounds - 1);
                end else begin
                    add_round(n, pick_witness(n), r == rounds - 1);
                end
                sent++;
            end
        end
    end

    // Reset and end-of-run control.
    initial begin
        aresetn = 1'b0;
        started = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        started = 1'b1;
        wait (pending_rounds.size() == 0 && !s_valid);
        wait (expected_verdicts.size() == 0);
        // A trailing non-final round may still be in progress.
        repeat (5000) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Request driver: updates on the falling edge.
    always @(negedge aclk) begin
        bit calm;
        calm = pending_rounds.size() < 30;
        if (!started) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // Hold the request until it is accepted.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_rounds.size() > 0 &&
                     !(pending_rounds[0].drain_first && expected_verdicts.size() > 0)) begin
            s_candidate <= pending_rounds[0].candidate;
            s_witness <= pending_rounds[0].witness;
            s_last_round <= pending_rounds[0].last_round;
            void'(pending_rounds.pop_front());
            s_valid <= 1'b1;
            if (!calm && $urandom_range(3) == 0) begin
                send_gap <= $urandom_range(12, 1);
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result receiver stalls: updates on the falling edge.
    always @(negedge aclk) begin
        if (!started || pending_rounds.size() < 30) begin
            m_ready <= 1'b1;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
            recv_gap <= $urandom_range(11, 0);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Accepted requests update the predicted flag and verdict queue.
    always @(posedge aclk) begin
        bit flag;
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            flag = composite_flag | round_is_composite(s_candidate, s_witness);
            if (s_last_round) begin
                expected_verdicts.push_back(!flag);
                flag = 1'b0;
            end
            composite_flag <= flag;
        end
    end

    // Verdict monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("verdict with no round awaiting one");
            end else begin
                if (m_probable_prime !== expected_verdicts[0]) begin
                    report_mismatch($sformatf("probable_prime %0b, expected %0b",
                                              m_probable_prime, expected_verdicts[0]));
                end
                void'(expected_verdicts.pop_front());
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_candidate = '0;
        s_witness = '0;
        s_last_round = 1'b0;
        m_ready = 1'b1;
        req_taken = 1'b0;
        composite_flag = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        mismatches = 0;
        cycle_count = 0;
    end

endmodule

/* filelist.f */
src/mrrc_pkg.sv
src/mrrc_modmul.sv
src/mrrc_datapath.sv
src/mrrc_ctrl.sv
src/miller_rabin_round_checker.sv
test/tb_miller_rabin_round_checker.sv
